// ----- hw/rtl/lcs_pkg.sv -----
// Shared types and constants for the LCS length engine.
// No dependencies; used by lcs_length_engine, lcs_cell_unit and the testbench.
`timescale 1ns / 1ps

package lcs_pkg;

   localparam int MAX_LEN_DEF     = 128;
   localparam int SYMBOL_BITS_DEF = 8;

   localparam int OP_W   = 2;
   localparam int SYM_IN_W = 8;
   localparam int LEN_OUT_W = 8;

   localparam logic [OP_W-1:0] OP_APPEND_A = 2'd0;
   localparam logic [OP_W-1:0] OP_APPEND_B = 2'd1;
   localparam logic [OP_W-1:0] OP_COMPUTE  = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ROW,
      ST_READ,
      ST_CALC,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic row_start;
      logic step;
      logic first_row;
   } cell_ctrl_type;

endpackage

// ----- hw/rtl/lcs_length_engine.sv -----
// Top level of the LCS length engine: string stores, score row, walk sequencer.
// Depends on lcs_pkg, lcs_ram and lcs_cell_unit.
//
//   channel | direction | handshake            | payload
//   req     | in        | req_valid/req_stall  | req_operation, req_symbol
//   rsp     | out       | rsp_valid/rsp_stall  | rsp_lcs_length, rsp_overflow
//
// An append is accepted in ST_IDLE without a stall; a new item may follow in the next cycle.
// A compute walks the table: ST_ROW for each row, then ST_READ and ST_CALC for each cell,
// or goes straight to ST_DONE with an empty string; row reads and writes use separate ports.
// req_stall is high for the whole compute; the result waits in an output register,
// so appends go on while rsp_stall holds a transfer back.
// Reset clears the lengths, the overflow flag and the output valid; no memory clear pass.
`timescale 1ns / 1ps

module lcs_length_engine #(
   parameter int MAX_LEN     = lcs_pkg::MAX_LEN_DEF,
   parameter int SYMBOL_BITS = lcs_pkg::SYMBOL_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [lcs_pkg::OP_W-1:0]       req_operation,
   input  logic [lcs_pkg::SYM_IN_W-1:0]   req_symbol,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [lcs_pkg::LEN_OUT_W-1:0]  rsp_lcs_length,
   output logic                           rsp_overflow
);

   localparam int LEN_W = $clog2(MAX_LEN + 1);
   localparam int IDX_W = $clog2(MAX_LEN);
   localparam int SAT_W = LEN_W + lcs_pkg::LEN_OUT_W;

   lcs_pkg::state_type state_ff, state_in;

   logic [LEN_W-1:0] len_a_ff, len_a_in;
   logic [LEN_W-1:0] len_b_ff, len_b_in;
   logic             ovf_ff, ovf_in;
   logic [LEN_W-1:0] i_ff, i_in;
   logic [LEN_W-1:0] j_ff, j_in;
   logic [LEN_W-1:0] last_ff, last_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [lcs_pkg::LEN_OUT_W-1:0] rsp_len_ff, rsp_len_in;
   logic             rsp_ovf_ff, rsp_ovf_in;

   logic [SYMBOL_BITS+lcs_pkg::SYM_IN_W-1:0] sym_ext;
   logic [SYMBOL_BITS-1:0] sym_w;
   logic [LEN_W-1:0] j_m1;
   logic [LEN_W-1:0] i_p1;
   logic [SAT_W-1:0] last_ext;
   logic [lcs_pkg::LEN_OUT_W-1:0] len_sat;

   logic a_we, b_we, a_re, b_re, row_re, row_we;
   logic [SYMBOL_BITS-1:0] a_sym, b_sym;
   logic [LEN_W-1:0] up_score, cell_score;
   lcs_pkg::cell_ctrl_type ctrl;

   assign sym_ext  = {{SYMBOL_BITS{1'b0}}, req_symbol};
   assign sym_w    = sym_ext[SYMBOL_BITS-1:0];
   assign j_m1     = j_ff - LEN_W'(1);
   assign i_p1     = i_ff + LEN_W'(1);
   assign last_ext = {{lcs_pkg::LEN_OUT_W{1'b0}}, last_ff};
   assign len_sat  = (last_ext > SAT_W'(255)) ? {lcs_pkg::LEN_OUT_W{1'b1}}
                                               : last_ext[lcs_pkg::LEN_OUT_W-1:0];

   lcs_ram #(.WIDTH(SYMBOL_BITS), .DEPTH(MAX_LEN)) u_store_a (
      .clock   (clock),
      .wr_en   (a_we),
      .wr_addr (len_a_ff[IDX_W-1:0]),
      .wr_data (sym_w),
      .rd_en   (a_re),
      .rd_addr (i_ff[IDX_W-1:0]),
      .rd_data (a_sym)
   );

   lcs_ram #(.WIDTH(SYMBOL_BITS), .DEPTH(MAX_LEN)) u_store_b (
      .clock   (clock),
      .wr_en   (b_we),
      .wr_addr (len_b_ff[IDX_W-1:0]),
      .wr_data (sym_w),
      .rd_en   (b_re),
      .rd_addr (j_m1[IDX_W-1:0]),
      .rd_data (b_sym)
   );

   lcs_ram #(.WIDTH(LEN_W), .DEPTH(MAX_LEN + 1)) u_score_row (
      .clock   (clock),
      .wr_en   (row_we),
      .wr_addr (j_ff),
      .wr_data (cell_score),
      .rd_en   (row_re),
      .rd_addr (j_ff),
      .rd_data (up_score)
   );

   lcs_cell_unit #(.SCORE_W(LEN_W), .SYM_W(SYMBOL_BITS)) u_cell (
      .clock      (clock),
      .ctrl       (ctrl),
      .a_sym      (a_sym),
      .b_sym      (b_sym),
      .up_score   (up_score),
      .cell_score (cell_score)
   );

   always_comb begin
      state_in     = state_ff;
      len_a_in     = len_a_ff;
      len_b_in     = len_b_ff;
      ovf_in       = ovf_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      last_in      = last_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      rsp_len_in   = rsp_len_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      a_we         = 1'b0;
      b_we         = 1'b0;
      a_re         = 1'b0;
      b_re         = 1'b0;
      row_re       = 1'b0;
      row_we       = 1'b0;
      ctrl         = '0;
      ctrl.first_row = (i_ff == '0);
      unique case (state_ff)
         lcs_pkg::ST_IDLE: begin
            if (req_valid) begin
               if (req_operation == lcs_pkg::OP_APPEND_A) begin
                  if (len_a_ff < LEN_W'(MAX_LEN)) begin
                     a_we     = 1'b1;
                     len_a_in = len_a_ff + LEN_W'(1);
                  end else begin
                     ovf_in = 1'b1;
                  end
               end else if (req_operation == lcs_pkg::OP_APPEND_B) begin
                  if (len_b_ff < LEN_W'(MAX_LEN)) begin
                     b_we     = 1'b1;
                     len_b_in = len_b_ff + LEN_W'(1);
                  end else begin
                     ovf_in = 1'b1;
                  end
               end else if (req_operation == lcs_pkg::OP_COMPUTE) begin
                  last_in = '0;
                  i_in    = '0;
                  if (len_a_ff == '0 || len_b_ff == '0) begin
                     state_in = lcs_pkg::ST_DONE;
                  end else begin
                     state_in = lcs_pkg::ST_ROW;
                  end
               end
            end
         end
         lcs_pkg::ST_ROW: begin
            a_re           = 1'b1;
            ctrl.row_start = 1'b1;
            j_in           = LEN_W'(1);
            state_in       = lcs_pkg::ST_READ;
         end
         lcs_pkg::ST_READ: begin
            b_re     = 1'b1;
            row_re   = 1'b1;
            state_in = lcs_pkg::ST_CALC;
         end
         lcs_pkg::ST_CALC: begin
            ctrl.step = 1'b1;
            row_we    = 1'b1;
            last_in   = cell_score;
            if (j_ff == len_b_ff) begin
               if (i_p1 == len_a_ff) begin
                  state_in = lcs_pkg::ST_DONE;
               end else begin
                  i_in     = i_p1;
                  state_in = lcs_pkg::ST_ROW;
               end
            end else begin
               j_in     = j_ff + LEN_W'(1);
               state_in = lcs_pkg::ST_READ;
            end
         end
         lcs_pkg::ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_len_in   = len_sat;
               rsp_ovf_in   = ovf_ff;
               len_a_in     = '0;
               len_b_in     = '0;
               ovf_in       = 1'b0;
               state_in     = lcs_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = lcs_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lcs_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_a_ff     <= '0;
         len_b_ff     <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         len_a_ff     <= len_a_in;
         len_b_ff     <= len_b_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      i_ff       <= i_in;
      j_ff       <= j_in;
      last_ff    <= last_in;
      rsp_len_ff <= rsp_len_in;
      rsp_ovf_ff <= rsp_ovf_in;
   end

   assign req_stall      = (state_ff != lcs_pkg::ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_lcs_length = rsp_len_ff;
   assign rsp_overflow   = rsp_ovf_ff;

   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      (len_a_ff <= LEN_W'(MAX_LEN)) && (len_b_ff <= LEN_W'(MAX_LEN)))
      else $error("string length beyond store depth");

   a_calc_index: assert property (@(posedge clock) disable iff (reset)
      (state_ff == lcs_pkg::ST_CALC) |->
         (j_ff != '0) && (j_ff <= len_b_ff) && (i_ff < len_a_ff))
      else $error("table walk index out of range");

   a_cell_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == lcs_pkg::ST_CALC) |-> (cell_score <= j_ff))
      else $error("cell score exceeds column");

   a_done_emit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == lcs_pkg::ST_DONE) && !(rsp_valid_ff && rsp_stall) |=>
         (state_ff == lcs_pkg::ST_IDLE) && rsp_valid_ff && (len_a_ff == '0)
         && (len_b_ff == '0) && !ovf_ff)
      else $error("compute finished without result or state release");

endmodule

// ----- hw/rtl/lcs_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module lcs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/lcs_cell_unit.sv -----
// Shared table cell unit: compare two symbols, take diagonal plus one or the larger
// neighbour, and hold the running diagonal and left scores. Depends on lcs_pkg.
`timescale 1ns / 1ps

module lcs_cell_unit #(
   parameter int SCORE_W = 8,
   parameter int SYM_W   = 8
) (
   input  logic                  clock,
   input  lcs_pkg::cell_ctrl_type ctrl,
   input  logic [SYM_W-1:0]      a_sym,
   input  logic [SYM_W-1:0]      b_sym,
   input  logic [SCORE_W-1:0]    up_score,
   output logic [SCORE_W-1:0]    cell_score
);

   logic [SCORE_W-1:0] diag_ff, diag_in;
   logic [SCORE_W-1:0] left_ff, left_in;
   logic [SCORE_W-1:0] up_eff;

   always_comb begin
      up_eff = ctrl.first_row ? '0 : up_score;
      if (a_sym == b_sym) begin
         cell_score = diag_ff + SCORE_W'(1);
      end else if (up_eff > left_ff) begin
         cell_score = up_eff;
      end else begin
         cell_score = left_ff;
      end
      diag_in = diag_ff;
      left_in = left_ff;
      if (ctrl.row_start) begin
         diag_in = '0;
         left_in = '0;
      end else if (ctrl.step) begin
         diag_in = up_eff;
         left_in = cell_score;
      end
   end

   always_ff @(posedge clock) begin
      diag_ff <= diag_in;
      left_ff <= left_in;
   end

endmodule

// ----- verif/lcs_length_engine_tb.sv -----
// Self-checking testbench for lcs_length_engine: loads symbol string pairs, computes,
// and checks each LCS length and overflow flag against a local dynamic-programming predictor.
// Depends on lcs_pkg and the lcs_length_engine RTL only.
`timescale 1ns / 1ps

module lcs_length_engine_tb;

   localparam int MAX_LEN   = lcs_pkg::MAX_LEN_DEF;
   localparam int OP_W      = lcs_pkg::OP_W;
   localparam int SYM_IN_W  = lcs_pkg::SYM_IN_W;
   localparam int LEN_OUT_W = lcs_pkg::LEN_OUT_W;
   localparam logic [SYM_IN_W-1:0] SYM_MASK =
      SYM_IN_W'((1 << lcs_pkg::SYMBOL_BITS_DEF) - 1);
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
   localparam int ITEMS_TARGET = 1800;
   localparam int STEADY_ITEMS = 150;
   localparam int LIMIT_CYCLES = 2_000_000;

   typedef struct {
      logic [LEN_OUT_W-1:0] lcs_length;
      logic                 overflow;
   } lcs_result_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic [OP_W-1:0]      req_operation = lcs_pkg::OP_APPEND_A;
   logic [SYM_IN_W-1:0]  req_symbol = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [LEN_OUT_W-1:0] rsp_lcs_length;
   logic                 rsp_overflow;

   logic [SYM_IN_W-1:0]  loaded_a[$];
   logic [SYM_IN_W-1:0]  loaded_b[$];
   logic                 overflow_pending = 1'b0;
   lcs_result_type       awaited_results[$];

   bit idle_on = 1'b1;
   int stall_left = 0;
   int items_sent = 0;
   int error_count = 0;
   int results_checked = 0;
   int overflow_results = 0;
   int longest_lcs = 0;

   lcs_length_engine u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_operation  (req_operation),
      .req_symbol     (req_symbol),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_lcs_length (rsp_lcs_length),
      .rsp_overflow   (rsp_overflow)
   );

   always #6 clock = ~clock;

   function automatic int lcs_of_loaded();
      int row [0:MAX_LEN];
      int diag;
      int up;
      int score;
      foreach (row[k]) row[k] = 0;
      foreach (loaded_a[i]) begin
         diag = 0;
         for (int j = 1; j <= loaded_b.size(); j++) begin
            up = row[j];
            if (loaded_a[i] == loaded_b[j-1]) score = diag + 1;
            else score = (up > row[j-1]) ? up : row[j-1];
            diag = up;
            row[j] = score;
         end
      end
      return (row[loaded_b.size()] > 255) ? 255 : row[loaded_b.size()];
   endfunction

   task automatic send_item(input logic [OP_W-1:0] op, input logic [SYM_IN_W-1:0] sym);
      int gap;
      lcs_result_type res;
      gap = 0;
      if (idle_on && $urandom_range(0, 7) == 0) gap = $urandom_range(1, 15);
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_operation <= op;
      req_symbol    <= sym;
      do @(posedge clock); while (req_stall);
      case (op)
         lcs_pkg::OP_APPEND_A: begin
            if (loaded_a.size() < MAX_LEN) loaded_a.push_back(sym & SYM_MASK);
            else overflow_pending = 1'b1;
         end
         lcs_pkg::OP_APPEND_B: begin
            if (loaded_b.size() < MAX_LEN) loaded_b.push_back(sym & SYM_MASK);
            else overflow_pending = 1'b1;
         end
         lcs_pkg::OP_COMPUTE: begin
            res.lcs_length = LEN_OUT_W'(lcs_of_loaded());
            res.overflow   = overflow_pending;
            awaited_results.push_back(res);
            loaded_a.delete();
            loaded_b.delete();
            overflow_pending = 1'b0;
         end
         default: ;
      endcase
      if (op != OP_UNUSED) items_sent++;
   endtask

   task automatic send_pair(input int len_a, input int len_b, input int alphabet);
      int na;
      int nb;
      na = 0;
      nb = 0;
      while (na < len_a || nb < len_b) begin
         if (nb >= len_b || (na < len_a && $urandom_range(0, 1) == 0)) begin
            send_item(lcs_pkg::OP_APPEND_A, SYM_IN_W'($urandom_range(0, alphabet - 1)));
            na++;
         end else begin
            send_item(lcs_pkg::OP_APPEND_B, SYM_IN_W'($urandom_range(0, alphabet - 1)));
            nb++;
         end
      end
      send_item(lcs_pkg::OP_COMPUTE, SYM_IN_W'($urandom_range(0, 255)));
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (awaited_results.size() != 0) @(posedge clock);
   endtask

   function automatic int pick_alphabet();
      case ($urandom_range(0, 3))
         0: return 2;
         1: return 4;
         2: return 16;
         default: return 256;
      endcase
   endfunction

   task automatic test_directed();
      send_item(lcs_pkg::OP_COMPUTE, 8'hFF);
      send_item(OP_UNUSED, 8'hFF);
      send_item(lcs_pkg::OP_APPEND_A, 8'h00);
      send_item(lcs_pkg::OP_APPEND_B, 8'h00);
      send_item(lcs_pkg::OP_COMPUTE, 8'h00);
      send_item(lcs_pkg::OP_APPEND_A, 8'hFF);
      send_item(lcs_pkg::OP_APPEND_B, 8'h00);
      send_item(lcs_pkg::OP_COMPUTE, 8'hA5);
      send_item(lcs_pkg::OP_APPEND_A, 8'hFF);
      send_item(OP_UNUSED, 8'h5A);
      send_item(lcs_pkg::OP_APPEND_B, 8'hFF);
      send_item(lcs_pkg::OP_COMPUTE, 8'h00);
      send_item(lcs_pkg::OP_APPEND_A, 8'h55);
      send_item(lcs_pkg::OP_APPEND_A, 8'hAA);
      send_item(lcs_pkg::OP_COMPUTE, 8'h00);
      send_item(lcs_pkg::OP_APPEND_B, 8'h12);
      send_item(lcs_pkg::OP_COMPUTE, 8'h00);
      send_item(lcs_pkg::OP_COMPUTE, 8'h00);
      send_item(lcs_pkg::OP_APPEND_B, 8'h80);
      send_item(lcs_pkg::OP_APPEND_A, 8'h01);
      send_item(lcs_pkg::OP_APPEND_A, 8'h80);
      send_item(lcs_pkg::OP_COMPUTE, 8'hFF);
   endtask

   task automatic test_full_strings();
      logic [SYM_IN_W-1:0] pattern [MAX_LEN];
      foreach (pattern[k]) pattern[k] = SYM_IN_W'($urandom_range(0, 255));
      foreach (pattern[k]) send_item(lcs_pkg::OP_APPEND_A, pattern[k]);
      foreach (pattern[k]) send_item(lcs_pkg::OP_APPEND_B, pattern[k]);
      send_item(lcs_pkg::OP_COMPUTE, 8'h00);
      drain_results();
      send_pair(MAX_LEN + 3, 4, 4);
      send_pair(3, MAX_LEN + 5, 4);
   endtask

   task automatic test_random_pairs();
      int kind;
      int huge_count;
      huge_count = 0;
      while (items_sent < ITEMS_TARGET - STEADY_ITEMS) begin
         kind = $urandom_range(0, 99);
         if (kind < 4) begin
            repeat ($urandom_range(1, 6))
               send_item(OP_W'($urandom_range(0, 3)), SYM_IN_W'($urandom_range(0, 255)));
         end else if (kind < 8) begin
            if ($urandom_range(0, 1)) send_pair($urandom_range(1, 10), 0, 256);
            else send_pair(0, $urandom_range(1, 10), 256);
            if ($urandom_range(0, 1))
               send_item(lcs_pkg::OP_COMPUTE, SYM_IN_W'($urandom_range(0, 255)));
         end else if (kind < 10 && huge_count < 2) begin
            send_pair($urandom_range(MAX_LEN - 8, MAX_LEN + 6),
                      $urandom_range(MAX_LEN - 8, MAX_LEN + 6), 4);
            huge_count++;
         end else if (kind < 22) begin
            send_pair($urandom_range(13, 40), $urandom_range(13, 40), pick_alphabet());
         end else begin
            send_pair($urandom_range(0, 12), $urandom_range(0, 12), pick_alphabet());
         end
         if ($urandom_range(0, 19) == 0) drain_results();
      end
   endtask

   task automatic test_steady_stream();
      idle_on = 1'b0;
      while (items_sent < ITEMS_TARGET)
         send_pair($urandom_range(0, 12), $urandom_range(0, 12), pick_alphabet());
   endtask

   always @(negedge clock) begin
      if (!idle_on) stall_left = 0;
      else if (stall_left == 0 && $urandom_range(0, 9) == 0) stall_left = $urandom_range(1, 15);
      if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      lcs_result_type exp_res;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (awaited_results.size() == 0) begin
            $error("rsp transfer with no result awaited: lcs_length %0d, overflow %0b",
                   rsp_lcs_length, rsp_overflow);
            error_count++;
         end else begin
            exp_res = awaited_results.pop_front();
            if (rsp_lcs_length !== exp_res.lcs_length) begin
               $error("lcs_length: expected %0d, actual %0d", exp_res.lcs_length,
                      rsp_lcs_length);
               error_count++;
            end
            if (rsp_overflow !== exp_res.overflow) begin
               $error("overflow: expected %0b, actual %0b", exp_res.overflow, rsp_overflow);
               error_count++;
            end
            results_checked++;
            if (exp_res.overflow) overflow_results++;
            if (exp_res.lcs_length > longest_lcs) longest_lcs = exp_res.lcs_length;
         end
      end
   end

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      drain_results();
      test_full_strings();
      drain_results();
      test_random_pairs();
      test_steady_stream();
      drain_results();
      repeat (64) @(posedge clock);
      $display("Covered %0d input transfers and %0d LCS results (%0d with overflow).",
               items_sent, results_checked, overflow_results);
      $display("Longest common subsequence seen: %0d symbols.", longest_lcs);
      if (error_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   initial begin
      repeat (LIMIT_CYCLES) @(posedge clock);
      $display("Timeout after %0d cycles with %0d results outstanding.", LIMIT_CYCLES,
               awaited_results.size());
      $display("Regression FAIL");
      $finish;
   end

endmodule
